// File: design/plbu_pkg.sv
// package for the price level book update block
// types, constants and codes shared by the level cell and the top level
// no dependencies
package plbu_pkg;

  localparam int BOOK_DEPTH    = 16;
  localparam int PRICE_BITS    = 16;
  localparam int QTY_BITS      = 32;
  localparam int CNT_W         = $clog2(BOOK_DEPTH + 1);
  localparam int STATUS_W      = 3;
  localparam int LEVEL_COUNT_W = 5;
  localparam int IN_TDATA_W    = ((PRICE_BITS + QTY_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((PRICE_BITS + QTY_BITS + LEVEL_COUNT_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_EVICTED  = 3'd4,
    ST_DROPPED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_DELETE,
    OP_INSERT
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic                  valid;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } level_t;

  typedef struct packed {
    logic                  cmp_en;
    logic                  is_ask;
    logic [PRICE_BITS-1:0] cmp_price;
    cell_op_e              op;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } cell_cmd_t;

endpackage

// File: design/plbu_cell.sv
// one price level cell of a book side: holds a level, compares and shifts
// with its neighbors under a broadcast command
// depends on plbu_pkg
module plbu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plbu_pkg::cell_cmd_t cmd_i,
  input  plbu_pkg::level_t   left_i,
  input  plbu_pkg::level_t   right_i,
  input  logic               left_ahead_i,
  output plbu_pkg::level_t   level_o,
  output logic               ahead_o,
  output logic               match_o
);
  import plbu_pkg::*;

  level_t level_q, level_d;
  logic   ahead_q, ahead_d;
  logic   match_q, match_d;

  // compare phase
  always_comb begin
    ahead_d = ahead_q;
    match_d = match_q;
    if (cmd_i.cmp_en) begin
      match_d = level_q.valid && (level_q.price == cmd_i.cmp_price);
      ahead_d = !level_q.valid ||
                (cmd_i.is_ask ? (cmd_i.cmp_price < level_q.price)
                              : (cmd_i.cmp_price > level_q.price));
    end
  end

  // apply phase
  always_comb begin
    level_d = level_q;
    case (cmd_i.op)
      OP_UPDATE: begin
        if (match_q) begin
          level_d.qty = cmd_i.qty;
        end
      end
      OP_DELETE: begin
        if (match_q || ahead_q) begin
          level_d = right_i;
        end
      end
      OP_INSERT: begin
        if (ahead_q && !left_ahead_i) begin
          level_d.valid = 1'b1;
          level_d.price = cmd_i.price;
          level_d.qty   = cmd_i.qty;
        end else if (left_ahead_i) begin
          level_d = left_i;
        end
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      ahead_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      level_q <= level_d;
      ahead_q <= ahead_d;
      match_q <= match_d;
    end
  end

  assign level_o = level_q;
  assign ahead_o = ahead_q;
  assign match_o = match_q;

endmodule

// File: design/price_level_book_update.sv
// top level of the price level book update block: two rows of level cells
// (bid, ask), request sequencing and the result register
// depends on plbu_pkg and plbu_cell
//
//   channel  dir  tdata (low bit up)                   tuser
//   s_axis   in   price[15:0], qty[47:16]              side
//   m_axis   out  best_price[15:0], best_qty[47:16],   status
//                 level_count[52:48]
//
// for each request the cells compare the price in the accept cycle, then
// shift, insert or update in the apply step that follows
// reset empties both sides at once, no clearing pass
// a result waits in its own register; a new request is taken meanwhile
// and its apply step stalls only while the previous result is not taken
module price_level_book_update (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [plbu_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,   // price, qty
  input  logic                               s_axis_tuser_i,   // side
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [plbu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,   // best_price, best_qty, level_count
  output logic [plbu_pkg::STATUS_W-1:0]      m_axis_tuser_o    // status
);
  import plbu_pkg::*;

  state_e                state_q, state_d;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QTY_BITS-1:0]   qty_q;
  logic [CNT_W-1:0]      cnt_q [2];
  logic                  out_valid_q;
  status_e               out_status_q;
  logic                  out_side_q;
  logic [CNT_W-1:0]      out_cnt_q;

  level_t                lvl     [2][BOOK_DEPTH];
  logic [BOOK_DEPTH-1:0] ahead_v [2];
  logic [BOOK_DEPTH-1:0] match_v [2];
  cell_cmd_t             cmd     [2];

  logic                  s_accept;
  logic                  do_apply;
  logic                  found;
  logic                  full;
  logic                  dropped;
  cell_op_e              op;
  status_e               status;
  logic [CNT_W-1:0]      cnt_cur;
  logic [CNT_W-1:0]      cnt_new;
  level_t                best;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign do_apply = (state_q == S_APPLY) && (!out_valid_q || m_axis_tready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_accept) state_d = S_APPLY;
      S_APPLY: if (do_apply) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    case (state_q)
      S_IDLE:  s_axis_tready_o = 1'b1;
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  // decision for the request in flight
  always_comb begin
    found   = |match_v[side_q];
    full    = lvl[side_q][BOOK_DEPTH-1].valid;
    dropped = !ahead_v[side_q][BOOK_DEPTH-1];
    cnt_cur = cnt_q[side_q];
    cnt_new = cnt_cur;
    op      = OP_NONE;
    status  = ST_ABSENT;
    if (qty_q == '0) begin
      if (found) begin
        op      = OP_DELETE;
        status  = ST_REMOVED;
        cnt_new = CNT_W'(cnt_cur - 1'b1);
      end
    end else if (found) begin
      op     = OP_UPDATE;
      status = ST_UPDATED;
    end else if (dropped) begin
      status = ST_DROPPED;
    end else if (full) begin
      op     = OP_INSERT;
      status = ST_EVICTED;
    end else begin
      op      = OP_INSERT;
      status  = ST_INSERTED;
      cnt_new = CNT_W'(cnt_cur + 1'b1);
    end
  end

  for (genvar s = 0; s < 2; s++) begin : g_side
    always_comb begin
      cmd[s].cmp_en    = s_accept && (s_axis_tuser_i == 1'(s));
      cmd[s].is_ask    = 1'(s);
      cmd[s].cmp_price = s_axis_tdata_i[PRICE_BITS-1:0];
      cmd[s].op        = (do_apply && (side_q == 1'(s))) ? op : OP_NONE;
      cmd[s].price     = price_q;
      cmd[s].qty       = qty_q;
    end

    for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      level_t left_lvl;
      level_t right_lvl;
      logic   left_ahead;

      if (i == 0) begin : g_head
        assign left_lvl   = '0;
        assign left_ahead = 1'b0;
      end else begin : g_body
        assign left_lvl   = lvl[s][i-1];
        assign left_ahead = ahead_v[s][i-1];
      end

      if (i == BOOK_DEPTH - 1) begin : g_tail
        assign right_lvl = '0;
      end else begin : g_mid
        assign right_lvl = lvl[s][i+1];
      end

      plbu_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .cmd_i        (cmd[s]),
        .left_i       (left_lvl),
        .right_i      (right_lvl),
        .left_ahead_i (left_ahead),
        .level_o      (lvl[s][i]),
        .ahead_o      (ahead_v[s][i]),
        .match_o      (match_v[s][i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q[0]     <= '0;
      cnt_q[1]     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_INSERTED;
      out_side_q   <= 1'b0;
      out_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (do_apply) begin
        cnt_q[side_q] <= cnt_new;
        out_valid_q   <= 1'b1;
        out_status_q  <= status;
        out_side_q    <= side_q;
        out_cnt_q     <= cnt_new;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      side_q  <= s_axis_tuser_i;
      price_q <= s_axis_tdata_i[PRICE_BITS-1:0];
      qty_q   <= s_axis_tdata_i[PRICE_BITS +: QTY_BITS];
    end
  end

  // book stays put while a result waits, so the top level is read directly
  always_comb begin
    best = lvl[out_side_q][0];
    if (!best.valid) begin
      best = '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({LEVEL_COUNT_W'(out_cnt_q), best.qty, best.price});

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(BOOK_DEPTH)) && (cnt_q[1] <= CNT_W'(BOOK_DEPTH)))
    else $error("level count above book depth");

  a_accept_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_APPLY))
    else $error("accepted request not followed by apply step");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_status_q == ST_DROPPED) || (out_status_q == ST_EVICTED)))
      |-> (out_cnt_q == CNT_W'(BOOK_DEPTH)))
    else $error("drop or eviction on a side that is not full");

  a_bid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] == CNT_W'(BOOK_DEPTH)) == lvl[0][BOOK_DEPTH-1].valid)
    else $error("bid count disagrees with last cell");

  a_ask_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[1] == CNT_W'(BOOK_DEPTH)) == lvl[1][BOOK_DEPTH-1].valid)
    else $error("ask count disagrees with last cell");

endmodule

// File: sim/tb_price_level_book_update.sv
// testbench for price_level_book_update: directed and random book updates on both sides
// a scoreboard class predicts status and top of book per request, checked on m_axis
// depends on plbu_pkg and the price_level_book_update rtl
module tb_price_level_book_update;
  timeunit 1ns;
  timeprecision 1ps;

  import plbu_pkg::*;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int MAX_WAIT        = 14;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AFTER      = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PRICE_WINDOW    = 24;
  localparam logic SIDE_BID      = 1'b0;
  localparam logic SIDE_ASK      = 1'b1;

  typedef struct packed {
    status_e                  status;
    logic [PRICE_BITS-1:0]    best_price;
    logic [QTY_BITS-1:0]      best_qty;
    logic [LEVEL_COUNT_W-1:0] level_count;
  } top_of_book_t;

  class book_tracker;
    logic [PRICE_BITS-1:0] lvl_price [2][BOOK_DEPTH];
    logic [QTY_BITS-1:0]   lvl_qty   [2][BOOK_DEPTH];
    int                    used      [2];
    top_of_book_t          expected_tops [$];
    int                    errors;
    int                    status_hits [6];

    function new();
      for (int s = 0; s < 2; s++) begin
        used[s] = 0;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
          lvl_price[s][i] = '0;
          lvl_qty[s][i]   = '0;
        end
      end
      errors = 0;
      for (int k = 0; k < 6; k++) status_hits[k] = 0;
    endfunction

    function bit ranks_ahead(bit is_ask, logic [PRICE_BITS-1:0] a, logic [PRICE_BITS-1:0] b);
      return is_ask ? (a < b) : (a > b);
    endfunction

    function void apply_request(bit is_ask, logic [PRICE_BITS-1:0] price,
                                logic [QTY_BITS-1:0] qty);
      int n;
      int found;
      int pos;
      int last;
      top_of_book_t top;
      n     = used[is_ask];
      found = -1;
      for (int i = 0; i < n; i++) begin
        if (found < 0 && lvl_price[is_ask][i] == price) found = i;
      end
      if (qty == '0) begin
        if (found >= 0) begin
          for (int i = found; i + 1 < n; i++) begin
            lvl_price[is_ask][i] = lvl_price[is_ask][i+1];
            lvl_qty[is_ask][i]   = lvl_qty[is_ask][i+1];
          end
          lvl_price[is_ask][n-1] = '0;
          lvl_qty[is_ask][n-1]   = '0;
          n--;
          top.status = ST_REMOVED;
        end else begin
          top.status = ST_ABSENT;
        end
      end else if (found >= 0) begin
        lvl_qty[is_ask][found] = qty;
        top.status = ST_UPDATED;
      end else begin
        pos = n;
        for (int i = 0; i < n; i++) begin
          if (pos == n && ranks_ahead(is_ask, price, lvl_price[is_ask][i])) pos = i;
        end
        if (pos >= BOOK_DEPTH) begin
          top.status = ST_DROPPED;
        end else begin
          if (n < BOOK_DEPTH) begin
            last = n;
            n++;
            top.status = ST_INSERTED;
          end else begin
            last = BOOK_DEPTH - 1;
            top.status = ST_EVICTED;
          end
          for (int i = last; i > pos; i--) begin
            lvl_price[is_ask][i] = lvl_price[is_ask][i-1];
            lvl_qty[is_ask][i]   = lvl_qty[is_ask][i-1];
          end
          lvl_price[is_ask][pos] = price;
          lvl_qty[is_ask][pos]   = qty;
        end
      end
      used[is_ask]     = n;
      top.best_price  = (n > 0) ? lvl_price[is_ask][0] : '0;
      top.best_qty    = (n > 0) ? lvl_qty[is_ask][0] : '0;
      top.level_count = LEVEL_COUNT_W'(n);
      expected_tops.push_back(top);
    endfunction

    function void check_top(logic [STATUS_W-1:0] status, logic [OUT_TDATA_W-1:0] tdata);
      top_of_book_t exp_top;
      if (expected_tops.size() == 0) begin
        $error("result with no request pending: status %0d tdata %h", status, tdata);
        errors++;
        return;
      end
      exp_top = expected_tops[0];
      expected_tops.delete(0);
      status_hits[int'(exp_top.status)]++;
      if (status !== exp_top.status) begin
        $error("status: expected %0d, got %0d", exp_top.status, status);
        errors++;
      end
      if (tdata[15:0] !== exp_top.best_price) begin
        $error("best_price: expected %0d, got %0d", exp_top.best_price, tdata[15:0]);
        errors++;
      end
      if (tdata[47:16] !== exp_top.best_qty) begin
        $error("best_qty: expected %0d, got %0d", exp_top.best_qty, tdata[47:16]);
        errors++;
      end
      if (tdata[52:48] !== exp_top.level_count) begin
        $error("level_count: expected %0d, got %0d", exp_top.level_count, tdata[52:48]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  book_tracker tracker = new();
  int          send_run    = 0;
  int          recv_run    = 0;
  int          results_seen = 0;
  bit          hold_active = 1'b0;

  price_level_book_update u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // mostly random waits, with occasional runs of back-to-back requests or results
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_request(logic is_ask, logic [PRICE_BITS-1:0] price,
                              logic [QTY_BITS-1:0] qty);
    int gap;
    gap = hold_active ? 0 : draw_wait(send_run);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qty, price};
    s_axis_tuser  <= is_ask;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_request(is_ask, price, qty);
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int stall_left;
    bit next_ready;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      next_ready = m_axis_tready;
      if (m_axis_tready && m_axis_tvalid) begin
        tracker.check_top(m_axis_tuser, m_axis_tdata);
        results_seen++;
        if (!hold_done && results_seen == HOLD_AFTER) begin
          hold_done   = 1'b1;
          hold_active = 1'b1;
          stall_left  = HOLD_CYCLES;
        end else begin
          stall_left = draw_wait(recv_run);
        end
        if (stall_left > 0) next_ready = 1'b0;
      end else if (!m_axis_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) begin
          next_ready  = 1'b1;
          hold_active = 1'b0;
        end
      end
      m_axis_tready <= next_ready;
    end
  end

  initial begin
    int                    bid_base;
    int                    ask_base;
    int                    roll;
    logic                  is_ask;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty side, extremes, unchanged-quantity update, deletes down to empty
    send_request(SIDE_ASK, 16'd100, 32'd0);
    send_request(SIDE_BID, 16'd0, 32'd1);
    send_request(SIDE_BID, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(SIDE_BID, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(SIDE_BID, 16'd0, 32'd0);
    send_request(SIDE_BID, 16'hFFFF, 32'd0);
    send_request(SIDE_ASK, 16'hFFFF, 32'hAAAA_AAAA);
    send_request(SIDE_ASK, 16'd0, 32'h5555_5555);
    // fill the bid side, then evict the worst and drop a worse price
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      send_request(SIDE_BID, 16'h8000 + 16'(2 * i), $urandom_range(1, 5000));
    end
    send_request(SIDE_BID, 16'h801F, 32'h0000_1234);
    send_request(SIDE_BID, 16'h7FFF, 32'd1);

    bid_base = $urandom_range(0, 65535 - PRICE_WINDOW);
    ask_base = $urandom_range(0, 65535 - PRICE_WINDOW);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 199) == 0) bid_base = $urandom_range(0, 65535 - PRICE_WINDOW);
      if ($urandom_range(0, 199) == 0) ask_base = $urandom_range(0, 65535 - PRICE_WINDOW);
      is_ask = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
        price = PRICE_BITS'((is_ask ? ask_base : bid_base) + $urandom_range(0, PRICE_WINDOW - 1));
      end else begin
        price = PRICE_BITS'($urandom_range(0, 65535));
      end
      roll = $urandom_range(0, 99);
      if (roll < 30) qty = '0;
      else if (roll < 70) qty = $urandom_range(1, 1000);
      else qty = $urandom;
      send_request(is_ask, price, qty);
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.expected_tops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d results: %0d inserted, %0d updated, %0d removed, %0d absent deletes,",
             results_seen, tracker.status_hits[0], tracker.status_hits[1],
             tracker.status_hits[2], tracker.status_hits[3]);
    $display("  %0d evictions, %0d drops; result side held off %0d cycles once",
             tracker.status_hits[4], tracker.status_hits[5], HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("[price_level_book_update] OK");
    end else begin
      $display("[price_level_book_update] ERROR");
    end
    $finish;
  end

  initial begin
    #2_500_000;
    $display("timeout waiting for results");
    $display("[price_level_book_update] ERROR");
    $finish;
  end

endmodule
